// ----- rtl/core/lstp_pkg.sv -----
// ----------------------------------------------------------------------------
// lstp_pkg
// Shared constants, types and the arctangent table for the laser scan to
// point converter.
// ----------------------------------------------------------------------------
package lstp_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NUM_CELLS     = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  // 2^30 / CORDIC gain, applied to the range before rotation
  localparam logic [29:0] GAIN_INV = 30'd652032874;

  localparam logic signed [17:0] OUT_MAX = 18'sd131071;
  localparam logic signed [17:0] OUT_MIN = -18'sd131072;

  typedef enum logic [2:0] {
    REG_ANGLE_START      = 3'd0,
    REG_ANGLE_STEP       = 3'd1,
    REG_RANGE_LOWER      = 3'd2,
    REG_RANGE_UPPER      = 3'd3,
    REG_YAW              = 3'd4,
    REG_OFFSET_X         = 3'd5,
    REG_OFFSET_Y         = 3'd6,
    REG_TRANSFORM_ENABLE = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [15:0] angle_start;
    logic [15:0] angle_step;
    logic [15:0] range_lower;
    logic [15:0] range_upper;
    logic [15:0] yaw;
    logic        transform_enable;
  } front_cfg_t;

  typedef struct packed {
    logic        valid;
    logic        ok;
    logic        last;
    logic [1:0]  quad;
    logic [13:0] zfrac;
    logic [29:0] mag;
  } front_t;

  typedef struct packed {
    logic               valid;
    logic               ok;
    logic               last;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cell_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 32'sd536870912;
      5'd1:  v = 32'sd316933406;
      5'd2:  v = 32'sd167458907;
      5'd3:  v = 32'sd85004756;
      5'd4:  v = 32'sd42667331;
      5'd5:  v = 32'sd21354465;
      5'd6:  v = 32'sd10679838;
      5'd7:  v = 32'sd5340245;
      5'd8:  v = 32'sd2670163;
      5'd9:  v = 32'sd1335087;
      5'd10: v = 32'sd667544;
      5'd11: v = 32'sd333772;
      5'd12: v = 32'sd166886;
      5'd13: v = 32'sd83443;
      5'd14: v = 32'sd41722;
      5'd15: v = 32'sd20861;
      5'd16: v = 32'sd10430;
      5'd17: v = 32'sd5215;
      5'd18: v = 32'sd2608;
      5'd19: v = 32'sd1304;
      5'd20: v = 32'sd652;
      5'd21: v = 32'sd326;
      5'd22: v = 32'sd163;
      5'd23: v = 32'sd81;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/lstp_cell.sv -----
// ----------------------------------------------------------------------------
// lstp_cell
// One CORDIC rotation stage: shift-add micro-rotation with a registered
// output handed to the next cell.
// ----------------------------------------------------------------------------
module lstp_cell
  import lstp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic [4:0] stage,
  input  cell_t      d,
  output cell_t      q
);

  logic               valid;
  logic               ok;
  logic               last;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] z;

  logic signed [31:0] xs;
  logic signed [31:0] ys;
  logic signed [31:0] ang;
  logic signed [31:0] x_next;
  logic signed [31:0] y_next;
  logic signed [31:0] z_next;

  always_comb begin
    xs  = d.x >>> stage;
    ys  = d.y >>> stage;
    ang = atan_entry(stage);
    if (!d.z[31]) begin
      x_next = d.x - ys;
      y_next = d.y + xs;
      z_next = d.z - ang;
    end else begin
      x_next = d.x + ys;
      y_next = d.y - xs;
      z_next = d.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok   <= d.ok;
      last <= d.last;
      x    <= x_next;
      y    <= y_next;
      z    <= z_next;
    end
  end

  assign q = '{valid: valid, ok: ok, last: last, x: x, y: y, z: z};

endmodule

// ----- rtl/core/lstp_front.sv -----
// ----------------------------------------------------------------------------
// lstp_front
// Input skid stage, beam angle tracking, range gate and gain prescale.
// ----------------------------------------------------------------------------
module lstp_front
  import lstp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  front_cfg_t  cfg,
  input  logic        beam_valid,
  output logic        beam_stall,
  input  logic [15:0] range,
  input  logic        range_finite,
  input  logic        last_beam,
  output front_t      q
);

  // skid entry
  logic        skid_full;
  logic [15:0] skid_range;
  logic        skid_finite;
  logic        skid_last;

  logic        accept;
  logic        entry_valid;
  logic [15:0] entry_range;
  logic        entry_finite;
  logic        entry_last;
  logic        take;

  logic [15:0] beam_angle;
  logic        at_scan_start;

  logic [15:0] angle;
  logic [15:0] theta;
  logic        ok;
  logic [45:0] product;

  logic        q_valid;
  logic        q_ok;
  logic        q_last;
  logic [1:0]  q_quad;
  logic [13:0] q_zfrac;
  logic [29:0] q_mag;

  assign beam_stall   = skid_full;
  assign accept       = beam_valid && !skid_full;
  assign entry_valid  = skid_full || beam_valid;
  assign entry_range  = skid_full ? skid_range  : range;
  assign entry_finite = skid_full ? skid_finite : range_finite;
  assign entry_last   = skid_full ? skid_last   : last_beam;
  assign take         = adv && entry_valid;

  always_comb begin
    angle   = at_scan_start ? cfg.angle_start : beam_angle;
    theta   = cfg.transform_enable ? angle + cfg.yaw : angle;
    ok      = entry_finite && (entry_range >= cfg.range_lower)
              && (entry_range <= cfg.range_upper);
    product = 46'(entry_range) * 46'(GAIN_INV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full     <= 1'b0;
      beam_angle    <= '0;
      at_scan_start <= 1'b1;
      q_valid       <= 1'b0;
    end else begin
      if (accept && !adv) begin
        skid_full <= 1'b1;
      end else if (adv) begin
        skid_full <= 1'b0;
      end
      if (take) begin
        beam_angle    <= angle + cfg.angle_step;
        at_scan_start <= entry_last;
      end
      if (adv) begin
        q_valid <= entry_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !adv) begin
      skid_range  <= range;
      skid_finite <= range_finite;
      skid_last   <= last_beam;
    end
    if (adv) begin
      q_ok    <= ok;
      q_last  <= entry_last;
      q_quad  <= theta[15:14];
      q_zfrac <= theta[13:0];
      q_mag   <= product[45:16];
    end
  end

  assign q = '{valid: q_valid, ok: q_ok, last: q_last, quad: q_quad,
               zfrac: q_zfrac, mag: q_mag};

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_full && !adv |=> skid_full && $stable(skid_range))
    else $error("skid entry lost while pipeline stalled");

  a_scan_restart: assert property (@(posedge clk) disable iff (rst)
    take && entry_last |=> at_scan_start)
    else $error("last beam did not restart the scan angle");

endmodule

// ----- rtl/core/laser_scan_to_points.sv -----
// ----------------------------------------------------------------------------
// laser_scan_to_points
// Laser range samples to x,y points through a chain of CORDIC cells.
// Path: front register, CORDIC cells, output register. Throughput: one beam
// per cycle unless the output stalls, set by the pipelined cell chain; a
// one-entry input skid keeps taking a beam while a result waits.
// Reset clears the pipeline, restarts the scan angle and loads register
// defaults (all zero, range_upper all ones).
// ----------------------------------------------------------------------------
module laser_scan_to_points
  import lstp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               beam_valid,
  output logic               beam_stall,
  input  logic [15:0]        range,
  input  logic               range_finite,
  input  logic               last_beam,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [17:0] point_x,
  output logic signed [17:0] point_y,
  output logic               point_valid,
  output logic               scan_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  front_cfg_t         cfg;
  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;

  logic               adv;
  front_t             front_q;
  cell_t              chain [NUM_CELLS+1];
  cell_t              tail;

  logic signed [31:0] mag_s;
  logic signed [31:0] rnd_x;
  logic signed [31:0] rnd_y;
  logic signed [18:0] sum_x;
  logic signed [18:0] sum_y;
  logic signed [17:0] sat_x;
  logic signed [17:0] sat_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg      <= '{angle_start: '0, angle_step: '0, range_lower: '0,
                    range_upper: '1, yaw: '0, transform_enable: 1'b0};
      offset_x <= '0;
      offset_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_ANGLE_START:      cfg.angle_start      <= cfg_data;
        REG_ANGLE_STEP:       cfg.angle_step       <= cfg_data;
        REG_RANGE_LOWER:      cfg.range_lower      <= cfg_data;
        REG_RANGE_UPPER:      cfg.range_upper      <= cfg_data;
        REG_YAW:              cfg.yaw              <= cfg_data;
        REG_OFFSET_X:         offset_x             <= cfg_data;
        REG_OFFSET_Y:         offset_y             <= cfg_data;
        REG_TRANSFORM_ENABLE: cfg.transform_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the output holds an untaken result
  assign adv = !(result_valid && result_stall);

  lstp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .cfg          (cfg),
    .beam_valid   (beam_valid),
    .beam_stall   (beam_stall),
    .range        (range),
    .range_finite (range_finite),
    .last_beam    (last_beam),
    .q            (front_q)
  );

  // quadrant pre-rotation feeding the first cell
  always_comb begin
    mag_s = $signed({2'b00, front_q.mag});
    chain[0].valid = front_q.valid;
    chain[0].ok    = front_q.ok;
    chain[0].last  = front_q.last;
    chain[0].z     = $signed({2'b00, front_q.zfrac, 16'h0000});
    case (front_q.quad)
      2'd0: begin
        chain[0].x = mag_s;
        chain[0].y = '0;
      end
      2'd1: begin
        chain[0].x = '0;
        chain[0].y = mag_s;
      end
      2'd2: begin
        chain[0].x = -mag_s;
        chain[0].y = '0;
      end
      default: begin
        chain[0].x = '0;
        chain[0].y = -mag_s;
      end
    endcase
  end

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    lstp_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .adv   (adv),
      .stage (5'(g)),
      .d     (chain[g]),
      .q     (chain[g+1])
    );
  end

  assign tail = chain[NUM_CELLS];

  always_comb begin
    rnd_x = (tail.x + 32'sd8192) >>> 14;
    rnd_y = (tail.y + 32'sd8192) >>> 14;
    sum_x = 19'(rnd_x);
    sum_y = 19'(rnd_y);
    if (cfg.transform_enable) begin
      sum_x = sum_x + 19'(offset_x);
      sum_y = sum_y + 19'(offset_y);
    end
    if (sum_x[18] != sum_x[17]) begin
      sat_x = sum_x[18] ? OUT_MIN : OUT_MAX;
    end else begin
      sat_x = sum_x[17:0];
    end
    if (sum_y[18] != sum_y[17]) begin
      sat_y = sum_y[18] ? OUT_MIN : OUT_MAX;
    end else begin
      sat_y = sum_y[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      point_x     <= tail.ok ? sat_x : '0;
      point_y     <= tail.ok ? sat_y : '0;
      point_valid <= tail.ok;
      scan_done   <= tail.last;
    end
  end

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !point_valid |-> point_x == 18'sd0 && point_y == 18'sd0)
    else $error("rejected beam carries a nonzero point");

  a_tail_delivered: assert property (@(posedge clk) disable iff (rst)
    adv && tail.valid |=> result_valid)
    else $error("finished item did not reach the output register");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !result_valid)
    else $error("result valid right after reset");

endmodule
